@@ rtl/core/rgbfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rgbfb_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int BYTE_W      = 8;
  localparam int COLORS      = 3;
  localparam int HALVES      = 2;
  localparam int DATA_W      = BYTE_W * COLORS * HALVES;
  localparam int ROW_W       = 3;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ROT  = 2'd1,
    OP_SCAN = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX_WR,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic             issue;
    logic             last;
    logic             ent_vld;
    logic [ROW_W-1:0] row;
  } scan_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/rgbfb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/rgbfb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_ctrl
  import rgbfb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  localparam int AW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [4:0]        pixel_x_i,
  input  wire logic [3:0]        pixel_y_i,
  input  wire logic [2:0]        color_i,
  input  wire logic [ROW_W-1:0]  scan_row_i,
  input  wire logic              pipe_free_i,
  input  wire logic              pipe_busy_i,
  output logic                   ram_re_o,
  output logic [AW-1:0]          ram_raddr_o,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_waddr_o,
  output logic [DATA_W-1:0]      ram_wdata_o,
  input  wire logic [DATA_W-1:0] ram_rdata_i,
  output scan_tag_t              tag_o
);

  localparam int SW = AW + 1;

  state_e             state_q, state_d;
  logic [AW-1:0]      off_q, off_d;
  logic [COLUMNS-1:0] vld_q, vld_d;
  logic [AW-1:0]      waddr_q, waddr_d;
  logic [3:0]         y_q, y_d;
  logic [2:0]         color_q, color_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [AW-1:0]      col_q, col_d;
  logic               done_q, done_d;
  logic               ent_vld_q, ent_vld_d;

  logic               accept;
  logic               x_in_range;
  logic [AW-1:0]      x_phys;
  logic [AW-1:0]      col_phys;
  logic [DATA_W-1:0]  old_data;
  logic [DATA_W-1:0]  new_data;

  function automatic logic [AW-1:0] to_phys(logic [AW-1:0] c, logic [AW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(c) + SW'(off);
    if (sum >= SW'(COLUMNS)) begin
      sum = sum - SW'(COLUMNS);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign x_in_range = (int'(pixel_x_i) < COLUMNS);
  assign x_phys     = to_phys(AW'(pixel_x_i), off_q);
  assign col_phys   = to_phys(col_q, off_q);
  assign old_data   = ent_vld_q ? ram_rdata_i : '0;

  always_comb begin
    new_data = old_data;
    for (int b = 0; b < COLORS * HALVES; b++) begin
      for (int j = 0; j < BYTE_W; j++) begin
        if ((1'(b / COLORS) == y_q[3]) && (3'(j) == ~y_q[2:0])) begin
          new_data[b*BYTE_W + j] = color_q[COLORS - 1 - (b % COLORS)];
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    off_d       = off_q;
    vld_d       = vld_q;
    waddr_d     = waddr_q;
    y_d         = y_q;
    color_d     = color_q;
    row_d       = row_q;
    col_d       = col_q;
    done_d      = done_q;
    ent_vld_d   = ent_vld_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = x_phys;
    ram_we_o    = 1'b0;
    ram_waddr_o = waddr_q;
    ram_wdata_o = new_data;
    tag_o       = '0;
    tag_o.row   = row_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_SET: begin
              if (x_in_range) begin
                ram_re_o  = 1'b1;
                waddr_d   = x_phys;
                ent_vld_d = vld_q[x_phys];
                y_d       = pixel_y_i;
                color_d   = color_i;
                state_d   = ST_PIX_WR;
              end
            end
            OP_ROT: begin
              off_d = (off_q == '0) ? AW'(COLUMNS - 1) : off_q - 1'b1;
            end
            OP_SCAN: begin
              row_d   = scan_row_i;
              col_d   = '0;
              done_d  = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PIX_WR: begin
        ram_we_o        = 1'b1;
        vld_d[waddr_q]  = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        ram_raddr_o = col_phys;
        if (!done_q && pipe_free_i) begin
          ram_re_o      = 1'b1;
          tag_o.issue   = 1'b1;
          tag_o.last    = (col_q == AW'(COLUMNS - 1));
          tag_o.ent_vld = vld_q[col_phys];
          col_d         = col_q + 1'b1;
          if (col_q == AW'(COLUMNS - 1)) begin
            done_d = 1'b1;
          end
        end
        if (done_q && !pipe_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      off_q   <= '0;
      vld_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q   <= waddr_d;
    y_q       <= y_d;
    color_q   <= color_d;
    row_q     <= row_d;
    col_q     <= col_d;
    ent_vld_q <= ent_vld_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/rgbfb_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_out
  import rgbfb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scan_tag_t         tag_i,
  input  wire logic [DATA_W-1:0] ram_rdata_i,
  output logic                   pipe_free_o,
  output logic                   pipe_busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   upper_red_o,
  output logic                   upper_green_o,
  output logic                   upper_blue_o,
  output logic                   lower_red_o,
  output logic                   lower_green_o,
  output logic                   lower_blue_o,
  output logic [ROW_W-1:0]       row_address_o,
  output logic                   latch_last_o
);

  logic                       rd_vld_q;
  scan_tag_t                  rd_tag_q;
  logic                       out_valid_q;
  logic [COLORS*HALVES-1:0]   bits_q, bits_d;
  logic [ROW_W-1:0]           row_addr_q;
  logic                       last_q;
  logic                       move;
  logic [DATA_W-1:0]          dat;

  assign move        = rd_vld_q && (!out_valid_q || out_ready_i);
  assign pipe_free_o = !rd_vld_q || move;
  assign pipe_busy_o = rd_vld_q;
  assign dat         = rd_tag_q.ent_vld ? ram_rdata_i : '0;

  // one bit of the selected row from every color byte
  always_comb begin
    logic [BYTE_W-1:0] plane;
    plane = '0;
    for (int b = 0; b < COLORS * HALVES; b++) begin
      plane     = dat[b*BYTE_W +: BYTE_W];
      bits_d[b] = plane[rd_tag_q.row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tag_i.issue) begin
        rd_vld_q <= 1'b1;
      end else if (move) begin
        rd_vld_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.issue) begin
      rd_tag_q <= tag_i;
    end
    if (move) begin
      bits_q     <= bits_d;
      row_addr_q <= ~rd_tag_q.row;
      last_q     <= rd_tag_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign upper_red_o   = bits_q[0];
  assign upper_green_o = bits_q[1];
  assign upper_blue_o  = bits_q[2];
  assign lower_red_o   = bits_q[3];
  assign lower_green_o = bits_q[4];
  assign lower_blue_o  = bits_q[5];
  assign row_address_o = row_addr_q;
  assign latch_last_o  = last_q;

endmodule

`default_nettype wire

@@ rtl/core/rgb_matrix_framebuffer_scanout.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame buffer and row scanout for a two-half RGB LED matrix, one bit per color per
// pixel, held in one synchronous RAM of COLUMNS words of 48 bits. Operation 0 writes
// one pixel as a read-modify-write of its column word; a column beyond the panel is
// dropped. Operation 1 rotates all columns right by stepping a column offset register,
// so no data moves in the RAM. Operation 2 emits COLUMNS beats, one column per cycle
// while the sink is ready, through the RAM read register and the output register; the
// single RAM read port sets that rate. The buffer reads as all zeros after reset
// through per-column valid bits, so there is no clearing pass. Output enable, row
// dwell and row sequencing belong to the caller.

module rgb_matrix_framebuffer_scanout
  import rgbfb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [4:0]       pixel_x_i,
  input  wire logic [3:0]       pixel_y_i,
  input  wire logic [2:0]       color_i,
  input  wire logic [ROW_W-1:0] scan_row_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  upper_red_o,
  output logic                  upper_green_o,
  output logic                  upper_blue_o,
  output logic                  lower_red_o,
  output logic                  lower_green_o,
  output logic                  lower_blue_o,
  output logic [ROW_W-1:0]      row_address_o,
  output logic                  latch_last_o
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              pipe_free;
  logic              pipe_busy;
  scan_tag_t         tag;

  rgbfb_ctrl #(
    .COLUMNS(COLUMNS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .color_i    (color_i),
    .scan_row_i (scan_row_i),
    .pipe_free_i(pipe_free),
    .pipe_busy_i(pipe_busy),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata),
    .tag_o      (tag)
  );

  rgbfb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(COLUMNS)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata)
  );

  rgbfb_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag),
    .ram_rdata_i  (ram_rdata),
    .pipe_free_o  (pipe_free),
    .pipe_busy_o  (pipe_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .upper_red_o  (upper_red_o),
    .upper_green_o(upper_green_o),
    .upper_blue_o (upper_blue_o),
    .lower_red_o  (lower_red_o),
    .lower_green_o(lower_green_o),
    .lower_blue_o (lower_blue_o),
    .row_address_o(row_address_o),
    .latch_last_o (latch_last_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rgbfb_pkg::*;

  localparam int NCOL = COLUMNS_DEF;

  typedef struct packed {
    logic             u_red;
    logic             u_green;
    logic             u_blue;
    logic             l_red;
    logic             l_green;
    logic             l_blue;
    logic [ROW_W-1:0] row;
    logic             last;
  } column_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       operation_i = OP_NONE;
  logic [4:0]       pixel_x_i = '0;
  logic [3:0]       pixel_y_i = '0;
  logic [2:0]       color_i = '0;
  logic [ROW_W-1:0] scan_row_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             upper_red_o;
  logic             upper_green_o;
  logic             upper_blue_o;
  logic             lower_red_o;
  logic             lower_green_o;
  logic             lower_blue_o;
  logic [ROW_W-1:0] row_address_o;
  logic             latch_last_o;

  logic             gaps_on = 1'b1;

  // color planes per column: upper r/g/b then lower r/g/b, row l at bit 7-l
  logic [7:0]       frame_mem [NCOL][6];
  column_beat_t     expected_columns [$];

  int unsigned      mismatches = 0;
  int unsigned      columns_checked = 0;
  int unsigned      pixel_writes = 0;
  int unsigned      column_rotations = 0;
  int unsigned      row_scans = 0;
  int unsigned      ignored_ops = 0;

  rgb_matrix_framebuffer_scanout i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .color_i       (color_i),
    .scan_row_i    (scan_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .upper_red_o   (upper_red_o),
    .upper_green_o (upper_green_o),
    .upper_blue_o  (upper_blue_o),
    .lower_red_o   (lower_red_o),
    .lower_green_o (lower_green_o),
    .lower_blue_o  (lower_blue_o),
    .row_address_o (row_address_o),
    .latch_last_o  (latch_last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (gaps_on) begin
      out_ready_i <= ($urandom_range(0, 99) >= 37);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic apply_to_frame(op_e op, logic [4:0] x, logic [3:0] y, logic [2:0] c,
                                logic [2:0] r);
    logic [7:0]   saved [6];
    logic [2:0]   bitpos;
    int           half;
    column_beat_t beat;
    case (op)
      OP_SET: begin
        half   = int'(y[3]);
        bitpos = 3'd7 - y[2:0];
        for (int k = 0; k < 3; k++) begin
          frame_mem[x][k + 3 * half][bitpos] = c[2 - k];
        end
        pixel_writes++;
      end
      OP_ROT: begin
        saved = frame_mem[NCOL - 1];
        for (int col = NCOL - 1; col > 0; col--) begin
          frame_mem[col] = frame_mem[col - 1];
        end
        frame_mem[0] = saved;
        column_rotations++;
      end
      OP_SCAN: begin
        for (int col = 0; col < NCOL; col++) begin
          beat.u_red   = frame_mem[col][0][r];
          beat.u_green = frame_mem[col][1][r];
          beat.u_blue  = frame_mem[col][2][r];
          beat.l_red   = frame_mem[col][3][r];
          beat.l_green = frame_mem[col][4][r];
          beat.l_blue  = frame_mem[col][5][r];
          beat.row     = 3'd7 - r;
          beat.last    = (col == NCOL - 1);
          expected_columns.push_back(beat);
        end
        row_scans++;
      end
      default: begin
        ignored_ops++;
      end
    endcase
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_cmd(op_e op, logic [4:0] x, logic [3:0] y, logic [2:0] c,
                          logic [2:0] r);
    if (gaps_on && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 37);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pixel_x_i   <= x;
    pixel_y_i   <= y;
    color_i     <= c;
    scan_row_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    apply_to_frame(op, x, y, c, r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    column_beat_t want;
    column_beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{upper_red_o, upper_green_o, upper_blue_o, lower_red_o, lower_green_o,
              lower_blue_o, row_address_o, latch_last_o};
      if (expected_columns.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
      end else begin
        want = expected_columns.pop_front();
        columns_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: beat mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic test_blank_scan();
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd7);
  endtask

  task automatic test_pixel_corners();
    send_cmd(OP_SET, 5'd0, 4'd0, 3'd7, 3'd0);
    send_cmd(OP_SET, 5'd31, 4'd15, 3'd7, 3'd0);
    send_cmd(OP_SET, 5'd31, 4'd7, 3'd3, 3'd0);
    send_cmd(OP_SET, 5'd0, 4'd8, 3'd4, 3'd0);
    send_cmd(OP_SET, 5'd16, 4'd3, 3'd5, 3'd0);
    send_cmd(OP_SET, 5'd16, 4'd11, 3'd2, 3'd0);
    // row l shows at scan row 7-l
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd7);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd4);
    send_cmd(OP_SET, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd31, 4'd15, 3'd7, 3'd7);
  endtask

  task automatic test_rotate_wrap();
    send_cmd(OP_ROT, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd7);
    send_cmd(OP_ROT, 5'd31, 4'd15, 3'd7, 3'd7);
    send_cmd(OP_NONE, 5'd31, 4'd15, 3'd7, 3'd7);
    send_cmd(OP_NONE, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd3);
  endtask

  task automatic test_drain_pause();
    send_cmd(OP_SET, 5'd9, 4'd12, 3'd6, 3'd0);
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd4);
    wait_drained();
    send_cmd(OP_SCAN, 5'd0, 4'd0, 3'd0, 3'd4);
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned sel;
    op_e         op;
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on <= !(i >= 90 && i < 140);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        op = OP_SET;
      end else if (sel < 70) begin
        op = OP_ROT;
      end else if (sel < 93) begin
        op = OP_SCAN;
      end else begin
        op = OP_NONE;
      end
      send_cmd(op, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end
    gaps_on <= 1'b1;
  endtask

  initial begin
    for (int col = 0; col < NCOL; col++) begin
      for (int k = 0; k < 6; k++) begin
        frame_mem[col][k] = 8'h00;
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blank_scan();
    test_pixel_corners();
    test_rotate_wrap();
    test_drain_pause();
    test_random_traffic(187);
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d pixel writes, %0d rotations, %0d row scans, %0d unused ops",
             pixel_writes, column_rotations, row_scans, ignored_ops);
    $display("checked %0d column beats against the frame prediction", columns_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
